FILE: rtl/blc_pkg.sv
// ----------------------------------------------------------------------------
// blc_pkg: shared types, constants and float helpers
// Opcode codes, queue item layout, memory geometry and the float32/float64
// conversions used by the load/store unit.
// ----------------------------------------------------------------------------
package blc_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_WORDS = MEM_BYTES / 8;
  localparam int WORD_AW   = $clog2(MEM_WORDS);
  localparam int WIN_W     = 17;
  localparam int LIM_W     = $clog2(MEM_BYTES) + 1;

  typedef enum logic [3:0] {
    CMD_LI8   = 4'd0,
    CMD_LI16  = 4'd1,
    CMD_LI32  = 4'd2,
    CMD_LF32  = 4'd3,
    CMD_LF64  = 4'd4,
    CMD_SI8   = 4'd5,
    CMD_SI16  = 4'd6,
    CMD_SI32  = 4'd7,
    CMD_SF32  = 4'd8,
    CMD_SF64  = 4'd9,
    CMD_SXI1  = 4'd10,
    CMD_SXI8  = 4'd11,
    CMD_SXI16 = 4'd12
  } cmd_t;

  // Classified beat handed from the front end to the back end.
  typedef struct packed {
    logic               mem_op;      // needs a memory access
    logic               range_error; // rejected access
    cmd_t               cmd;
    logic [WORD_AW-1:0] word;        // first 64-bit word touched
    logic [2:0]         off;         // byte offset within that word
    logic [3:0]         size;        // access size in bytes
    logic [63:0]        value;       // operand, or finished result if !mem_op
  } blc_item_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RDA,
    BK_RDB,
    BK_EXEC,
    BK_WRB,
    BK_NORM,
    BK_FIN
  } bk_state_t;

  function automatic logic [3:0] size_of(input cmd_t c);
    logic [3:0] n;
    unique case (c)
      CMD_LI8, CMD_SI8:                      n = 4'd1;
      CMD_LI16, CMD_SI16:                    n = 4'd2;
      CMD_LI32, CMD_LF32, CMD_SI32, CMD_SF32: n = 4'd4;
      default:                               n = 4'd8;
    endcase
    return n;
  endfunction

  // Widen float32 to float64; subnormal inputs are normalized elsewhere.
  function automatic logic [63:0] widen_f32(input logic [31:0] f);
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] r;
    e = f[30:23];
    m = f[22:0];
    if (e == 8'hff) begin
      if (m == 23'd0) r = {f[31], 11'h7ff, 52'd0};
      else            r = {f[31], 11'h7ff, 1'b1, m[21:0], 29'd0};
    end else if (e == 8'd0) begin
      r = {f[31], 63'd0};
    end else begin
      r = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
    end
    return r;
  endfunction

  // Narrow float64 to float32, round to nearest even.
  function automatic logic [31:0] narrow_f64(input logic [63:0] d);
    logic              s;
    logic [10:0]       e;
    logic [51:0]       m;
    logic signed [12:0] fe;
    logic signed [12:0] shw;
    logic [5:0]        sh;
    logic [52:0]       full;
    logic [52:0]       q;
    logic [52:0]       lowmask;
    logic              guard;
    logic              sticky;
    logic [31:0]       r;
    s = d[63];
    e = d[62:52];
    m = d[51:0];
    fe = $signed({2'b00, e}) - 13'sd896;
    shw = (fe >= 13'sd1) ? 13'sd29 : (13'sd30 - fe);
    sh = shw[5:0];
    full = {1'b1, m};
    q = full >> sh;
    guard = full[sh - 6'd1];
    lowmask = (53'd1 << (sh - 6'd1)) - 53'd1;
    sticky = |(full & lowmask);
    if (guard && (sticky || q[0])) q = q + 53'd1;
    if (e == 11'h7ff) begin
      if (m == 52'd0) r = {s, 31'h7f800000};
      else            r = {s, 8'hff, 1'b1, m[50:29]};
    end else if (e == 11'd0) begin
      r = {s, 31'd0};
    end else if (fe >= 13'sd255) begin
      r = {s, 31'h7f800000};
    end else if (shw > 13'sd60) begin
      r = {s, 31'd0};
    end else if (fe >= 13'sd1) begin
      r = {s, 31'(({24'd0, fe[7:0]} << 23) + q[31:0] - 32'h0080_0000)};
    end else begin
      r = {s, q[30:0]};
    end
    return r;
  endfunction

endpackage

FILE: rtl/blc_front.sv
// ----------------------------------------------------------------------------
// blc_front: input classification
// Range-checks each beat, splits the address into word and offset, and
// finishes sign extension and rejected accesses without the memory.
// ----------------------------------------------------------------------------
module blc_front (
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              cmd,
  input  logic [31:0]             addr,
  input  logic [63:0]             value,
  input  logic [blc_pkg::WIN_W-1:0] window_length,
  input  logic                    clearing,
  input  logic                    q_full,
  output logic                    q_push,
  output blc_pkg::blc_item_t      q_item
);
  import blc_pkg::*;

  cmd_t             c;
  logic [3:0]       n;
  logic [LIM_W-1:0] lim;
  logic [32:0]      last;
  logic             bad;

  // Hold off while the queue is full or memory is still being cleared.
  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;

  assign c = cmd_t'(cmd);
  assign n = size_of(c);

  // Clamp the window to the store and check the byte range.
  always_comb begin
    if (LIM_W > WIN_W && 32'(window_length) < 32'(MEM_BYTES))
      lim = LIM_W'(window_length);
    else if (LIM_W <= WIN_W && 32'(window_length) < 32'(MEM_BYTES))
      lim = LIM_W'(window_length);
    else
      lim = LIM_W'(MEM_BYTES);
  end

  assign last = {2'b00, addr[30:0]} + 33'(n);
  assign bad  = addr[31] | (last > 33'(lim));

  // Build the queue beat; a rejected access carries a zero result.
  always_comb begin
    q_item.cmd         = c;
    q_item.word        = addr[WORD_AW+2:3];
    q_item.off         = addr[2:0];
    q_item.size        = n;
    q_item.mem_op      = 1'b0;
    q_item.range_error = 1'b0;
    q_item.value       = 64'd0;
    unique case (c)
      CMD_LI8, CMD_LI16, CMD_LI32, CMD_LF32, CMD_LF64,
      CMD_SI8, CMD_SI16, CMD_SI32, CMD_SF32, CMD_SF64: begin
        q_item.mem_op      = ~bad;
        q_item.range_error = bad;
        q_item.value       = bad ? 64'd0 : value;
      end
      CMD_SXI1:  q_item.value = {32'd0, {32{value[0]}}};
      CMD_SXI8:  q_item.value = {32'd0, {24{value[7]}}, value[7:0]};
      CMD_SXI16: q_item.value = {32'd0, {16{value[15]}}, value[15:0]};
      default:   q_item.value = 64'd0;
    endcase
  end

endmodule

FILE: rtl/blc_queue.sv
// ----------------------------------------------------------------------------
// blc_queue: two-entry beat queue
// Decouples the front end from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module blc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  blc_pkg::blc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output blc_pkg::blc_item_t head
);
  import blc_pkg::*;

  blc_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Store the incoming beat.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

FILE: rtl/blc_back.sv
// ----------------------------------------------------------------------------
// blc_back: memory execution
// Owns the byte store as 64-bit words, clears it after reset, and reads two
// words for each access, writing both back for a store. Holds the output register.
// ----------------------------------------------------------------------------
module blc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  blc_pkg::blc_item_t q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        result_bits,
  output logic               result_is_float,
  output logic               range_error
);
  import blc_pkg::*;

  logic [63:0] mem [MEM_WORDS];

  bk_state_t          state, state_next;
  logic [WORD_AW-1:0] clr_cnt;
  blc_item_t          cur;
  logic [63:0]        lo;
  logic [63:0]        hi_wr;
  logic [63:0]        res_bits;
  logic               res_float;
  logic               res_err;
  logic [22:0]        norm_m;
  logic [4:0]         norm_p;
  logic               s_bit;

  logic               mem_we;
  logic [WORD_AW-1:0] mem_wa;
  logic [63:0]        mem_wd;
  logic [WORD_AW-1:0] mem_ra;
  logic [63:0]        rdata;
  logic               out_free;
  logic               start;

  logic [127:0] both;
  logic [63:0]  raw;
  logic [15:0]  bmask;
  logic [63:0]  sval;
  logic [127:0] sdata;
  logic [127:0] merged;
  logic         lf_sub;
  logic [63:0]  ld_res;

  assign clearing = (state == BK_CLEAR);
  assign out_free = ~out_valid | ~out_stall;
  assign start    = (state == BK_IDLE) & q_valid;
  assign q_pop    = start;

  // Word store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  // Line up the two words and pick out or merge the accessed bytes.
  always_comb begin
    both   = {rdata, lo};
    raw    = 64'(both >> {cur.off, 3'b000});
    bmask  = 16'(((16'd1 << cur.size) - 16'd1) << cur.off);
    sval   = (cur.cmd == CMD_SF32) ? {32'd0, narrow_f64(cur.value)} : cur.value;
    sdata  = {64'd0, sval} << {cur.off, 3'b000};
    for (int i = 0; i < 16; i++) begin
      merged[i*8 +: 8] = bmask[i] ? sdata[i*8 +: 8] : both[i*8 +: 8];
    end
    lf_sub = (raw[30:23] == 8'd0) && (raw[22:0] != 23'd0);
    unique case (cur.cmd)
      CMD_LI8:  ld_res = {56'd0, raw[7:0]};
      CMD_LI16: ld_res = {48'd0, raw[15:0]};
      CMD_LI32: ld_res = {32'd0, raw[31:0]};
      CMD_LF32: ld_res = widen_f32(raw[31:0]);
      CMD_LF64: ld_res = raw;
      default:  ld_res = 64'd0;
    endcase
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_wa     = cur.word;
    mem_wd     = merged[63:0];
    mem_ra     = cur.word;
    unique case (state)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = 64'd0;
        if (clr_cnt == WORD_AW'(MEM_WORDS - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        mem_ra = q_head.word;
        if (q_valid) state_next = q_head.mem_op ? BK_RDA : BK_FIN;
      end
      BK_RDA: begin
        mem_ra     = cur.word + WORD_AW'(1);
        state_next = BK_RDB;
      end
      // Keep the upper word on the read port for the execute cycle.
      BK_RDB: begin
        mem_ra     = cur.word + WORD_AW'(1);
        state_next = BK_EXEC;
      end
      BK_EXEC: begin
        if (cur.cmd == CMD_SI8 || cur.cmd == CMD_SI16 || cur.cmd == CMD_SI32 ||
            cur.cmd == CMD_SF32 || cur.cmd == CMD_SF64) begin
          mem_we     = 1'b1;
          state_next = BK_WRB;
        end else if (cur.cmd == CMD_LF32 && lf_sub) begin
          state_next = BK_NORM;
        end else begin
          state_next = BK_FIN;
        end
      end
      BK_WRB: begin
        mem_we     = 1'b1;
        mem_wa     = cur.word + WORD_AW'(1);
        mem_wd     = hi_wr;
        state_next = BK_FIN;
      end
      BK_NORM: if (norm_m[22]) state_next = BK_FIN;
      BK_FIN:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_cnt <= clr_cnt + WORD_AW'(1);
      if (state == BK_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall)             out_valid <= 1'b0;
    end
  end

  // Working payload: latch the beat, collect words, build the result.
  always_ff @(posedge clk) begin
    if (start) begin
      cur       <= q_head;
      res_bits  <= q_head.mem_op ? 64'd0 : q_head.value;
      res_float <= 1'b0;
      res_err   <= q_head.range_error;
    end
    if (state == BK_RDA) lo <= rdata;
    if (state == BK_EXEC) begin
      hi_wr     <= merged[127:64];
      res_bits  <= ld_res;
      res_float <= (cur.cmd == CMD_LF32) || (cur.cmd == CMD_LF64);
      norm_m    <= raw[22:0];
      norm_p    <= 5'd22;
      s_bit     <= raw[31];
    end
    // Shift a subnormal single up one bit a cycle until its leading one.
    if (state == BK_NORM) begin
      if (norm_m[22]) begin
        res_bits <= {s_bit, 11'({6'd0, norm_p} + 11'd874), norm_m[21:0], 30'd0};
      end else begin
        norm_m <= {norm_m[21:0], 1'b0};
        norm_p <= norm_p - 5'd1;
      end
    end
    if (state == BK_FIN && out_free) begin
      result_bits     <= res_bits;
      result_is_float <= res_float;
      range_error     <= res_err;
    end
  end

endmodule

FILE: rtl/bounds_checked_load_store_unit.sv
// Sequence: a load passes the back-end states IDLE, RDA, RDB, EXEC and FIN;
// a store adds WRB after EXEC, sign extension or a rejected access goes from
// IDLE to FIN, and an lf32 of a subnormal adds NORM. The back end takes one
// beat at a time, through its two-word read and, for a store, write-back.
// Reset: window_length returns to 1024 and a clearing pass writes zero to all
// 8192 words while the input stalls.
// ----------------------------------------------------------------------------
// bounds_checked_load_store_unit: top level
// Front end classifies beats, a short queue decouples it from the back end,
// which executes them against the byte store.
// ----------------------------------------------------------------------------
module bounds_checked_load_store_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  cmd,
  input  logic [31:0] addr,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_bits,
  output logic        result_is_float,
  output logic        range_error,
  input  logic        window_length_we,
  input  logic [16:0] window_length_wdata
);
  import blc_pkg::*;

  logic [WIN_W-1:0] window_length;
  logic             clearing;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  blc_item_t        q_in;
  blc_item_t        q_head;

  // Window register.
  always_ff @(posedge clk) begin
    if (rst) window_length <= WIN_W'(1024);
    else if (window_length_we) window_length <= window_length_wdata;
  end

  blc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .addr          (addr),
    .value         (value),
    .window_length (window_length),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  blc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  blc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_bits     (result_bits),
    .result_is_float (result_is_float),
    .range_error     (range_error)
  );

  // No beat may enter while the store is being cleared.
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("input accepted during clearing pass");

  // A rejected access reports nothing else.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (result_bits == 64'd0 && !result_is_float))
    else $error("range error with nonzero result");

  // Queue never pops empty.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

FILE: tb/bounds_checked_load_store_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounds_checked_load_store_unit_tb: self-checking testbench
// Drives memory opcodes through the valid/stall input channel and checks
// each result beat against a local model of the byte store. The model covers
// little-endian access, float widening and narrowing, and range checks.
// The window register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module bounds_checked_load_store_unit_tb;
  import blc_pkg::*;

  localparam int MEM_SIZE  = 65536;
  localparam int WDOG_MAX  = 40000;
  localparam int RAND_BEATS = 620;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] addr;
    logic [63:0] value;
  } op_beat_t;

  typedef struct {
    logic [63:0] bits;
    logic        is_float;
    logic        rerr;
  } load_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  cmd = '0;
  logic [31:0] addr = '0;
  logic [63:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_bits;
  logic        result_is_float;
  logic        range_error;
  logic        window_length_we = 1'b0;
  logic [16:0] window_length_wdata = '0;

  op_beat_t     pending_ops[$];
  load_result_t expected_results[$];
  logic [7:0]   model_mem[MEM_SIZE];
  logic [16:0]  model_window;
  int           error_count = 0;
  int           wdog = 0;
  bit           calm = 1'b0;   // no idling on either side
  bit           hold_input = 1'b0;

  bounds_checked_load_store_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .addr(addr), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_bits(result_bits), .result_is_float(result_is_float),
    .range_error(range_error),
    .window_length_we(window_length_we),
    .window_length_wdata(window_length_wdata)
  );

  always #5 clk = ~clk;

  // Widen a single to a double exactly, subnormals normalized.
  function automatic logic [63:0] single_to_double(input logic [31:0] f);
    logic [63:0] sgn;
    logic [7:0]  e;
    logic [63:0] m;
    int          p;
    sgn = {f[31], 63'd0};
    e = f[30:23];
    m = {41'd0, f[22:0]};
    if (e == 8'hff) begin
      if (m == 0) return sgn | 64'h7ff0_0000_0000_0000;
      return sgn | 64'h7ff8_0000_0000_0000 | (m << 29);
    end
    if (e == 0) begin
      if (m == 0) return sgn;
      p = 22;
      while (m[p] == 1'b0) p--;
      return sgn | (64'(p + 874) << 52) | ((m << (52 - p)) & 64'h000f_ffff_ffff_ffff);
    end
    return sgn | (64'(e + 896) << 52) | (m << 29);
  endfunction

  // Narrow a double to a single, round to nearest even.
  function automatic logic [31:0] double_to_single(input logic [63:0] d);
    logic [31:0] sgn;
    int          e, fe, sh;
    logic [63:0] m, full, q, rem, half;
    sgn = {d[63], 31'd0};
    e = int'(d[62:52]);
    m = d & 64'h000f_ffff_ffff_ffff;
    if (e == 'h7ff) begin
      if (m == 0) return sgn | 32'h7f80_0000;
      return sgn | 32'h7fc0_0000 | 32'(m >> 29);
    end
    if (e == 0) return sgn;
    fe = e - 896;
    if (fe >= 255) return sgn | 32'h7f80_0000;
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 60) return sgn;
    full = m | 64'h0010_0000_0000_0000;
    q = full >> sh;
    rem = full & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (fe >= 1) return sgn | ((32'(fe) << 23) + 32'(q) - 32'h0080_0000);
    return sgn | 32'(q);
  endfunction

  function automatic logic [63:0] mem_read(input int a, input int n);
    logic [63:0] v = '0;
    for (int i = 0; i < n; i++) v |= 64'(model_mem[a + i]) << (8 * i);
    return v;
  endfunction

  function automatic void mem_write(input int a, input int n, input logic [63:0] v);
    for (int i = 0; i < n; i++) model_mem[a + i] = v[8 * i +: 8];
  endfunction

  function automatic int access_bytes(input logic [3:0] c);
    case (c)
      CMD_LI8, CMD_SI8:                       return 1;
      CMD_LI16, CMD_SI16:                     return 2;
      CMD_LI32, CMD_LF32, CMD_SI32, CMD_SF32: return 4;
      default:                                return 8;
    endcase
  endfunction

  // Execute one beat on the model store and return its result.
  function automatic load_result_t execute_op(input op_beat_t b);
    load_result_t r;
    longint       lim;
    int           n;
    logic [31:0]  v32;
    r = '{64'd0, 1'b0, 1'b0};
    v32 = b.value[31:0];
    if (b.cmd <= CMD_SF64) begin
      n = access_bytes(b.cmd);
      lim = (model_window > MEM_SIZE) ? MEM_SIZE : model_window;
      if (b.addr[31] || longint'(b.addr) + n > lim) begin
        r.rerr = 1'b1;
      end else begin
        case (cmd_t'(b.cmd))
          CMD_LI8, CMD_LI16, CMD_LI32: r.bits = mem_read(int'(b.addr), n);
          CMD_LF32: begin
            r.bits = single_to_double(mem_read(int'(b.addr), 4));
            r.is_float = 1'b1;
          end
          CMD_LF64: begin
            r.bits = mem_read(int'(b.addr), 8);
            r.is_float = 1'b1;
          end
          CMD_SI8, CMD_SI16, CMD_SI32: mem_write(int'(b.addr), n, {32'd0, v32});
          CMD_SF32: mem_write(int'(b.addr), 4, {32'd0, double_to_single(b.value)});
          default:  mem_write(int'(b.addr), 8, b.value);
        endcase
      end
    end else if (b.cmd == CMD_SXI1) begin
      r.bits = {32'd0, {32{v32[0]}}};
    end else if (b.cmd == CMD_SXI8) begin
      r.bits = {32'd0, {24{v32[7]}}, v32[7:0]};
    end else if (b.cmd == CMD_SXI16) begin
      r.bits = {32'd0, {16{v32[15]}}, v32[15:0]};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Driver: present queued beats, idle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && !hold_input &&
            (calm || $urandom_range(99) >= 35)) begin
          op_beat_t b;
          b = pending_ops.pop_front();
          expected_results.push_back(execute_op(b));
          cmd <= b.cmd;
          addr <= b.addr;
          value <= b.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", result_bits, 64'd0);
        end else begin
          load_result_t e;
          e = expected_results.pop_front();
          if (result_bits !== e.bits) report_mismatch("result_bits", result_bits, e.bits);
          if (result_is_float !== e.is_float)
            report_mismatch("result_is_float", 64'(result_is_float), 64'(e.is_float));
          if (range_error !== e.rerr)
            report_mismatch("range_error", 64'(range_error), 64'(e.rerr));
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_op(input logic [3:0] c, input logic [31:0] a, input logic [63:0] v);
    op_beat_t b;
    b.cmd = c;
    b.addr = a;
    b.value = v;
    pending_ops.push_back(b);
  endtask

  // Wait until everything sent has come back, then let the pipe drain.
  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(input logic [16:0] w);
    window_length_wdata <= w;
    window_length_we <= 1'b1;
    @(posedge clk);
    window_length_we <= 1'b0;
    model_window = w;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random beat: mostly in-window accesses near a hot region.
  task automatic queue_random_op(input int span);
    logic [3:0]  c;
    logic [31:0] a;
    logic [63:0] v;
    int          k;
    c = 4'($urandom_range(15));
    if ($urandom_range(99) < 3) c = 4'($urandom_range(13, 15));
    else if (c > 12) c = 4'($urandom_range(12));
    k = $urandom_range(99);
    if (k < 75) a = 32'($urandom_range(span - 1));
    else if (k < 85) a = 32'(model_window) - 32'($urandom_range(9));
    else if (k < 92) a = $urandom;
    else a = 32'($urandom_range(MEM_SIZE + 8));
    v = rand64();
    case ($urandom_range(7))
      0: v = {1'b0, 11'h7ff, v[51:0]};
      1: v = {v[63], 11'($urandom_range(860, 1160)), v[51:0]};
      2: v = {v[63], 11'($urandom_range(880, 900)), v[51:0]};
      default: ;
    endcase
    queue_op(c, a, v);
  endtask

  initial begin
    model_window = 17'd1024;
    for (int i = 0; i < MEM_SIZE; i++) model_mem[i] = 8'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every opcode, edges of the window.
    calm = 1'b1;
    queue_op(CMD_LI8, 32'd0, 64'd0);
    queue_op(CMD_SF64, 32'd1016, 64'hffff_ffff_ffff_ffff);
    queue_op(CMD_LF64, 32'd1016, 64'd0);
    queue_op(CMD_LI32, 32'd1020, 64'd0);
    queue_op(CMD_LI8, 32'd1024, 64'd0);
    queue_op(CMD_SI16, 32'd1023, 64'd5);
    queue_op(CMD_LI16, 32'h8000_0000, 64'd0);
    queue_op(CMD_LI32, 32'h7fff_ffff, 64'd0);
    queue_op(CMD_SI32, 32'd3, 64'h0000_0000_8765_4321);
    queue_op(CMD_LI16, 32'd4, 64'd0);
    queue_op(CMD_SI8, 32'd9, 64'h0000_0000_0000_00a5);
    queue_op(CMD_SF32, 32'd16, 64'h3ff0_0000_0000_0001);
    queue_op(CMD_SF32, 32'd20, 64'h47f0_0000_0000_0000);
    queue_op(CMD_SF32, 32'd24, 64'h7ff4_0000_0000_1234);
    queue_op(CMD_SF32, 32'd28, 64'h3690_0000_0000_0000);
    queue_op(CMD_SF32, 32'd32, 64'h8000_0000_0000_0000);
    queue_op(CMD_SI32, 32'd36, 64'h0000_0000_0000_0001);
    queue_op(CMD_SI32, 32'd40, 64'h0000_0000_7fa0_0001);
    for (int i = 16; i <= 40; i += 4) queue_op(CMD_LF32, 32'(i), 64'd0);
    queue_op(CMD_SXI1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff);
    queue_op(CMD_SXI8, 32'd0, 64'h0000_0000_0000_0080);
    queue_op(CMD_SXI16, 32'd0, 64'h0000_0000_0000_7fff);
    queue_op(4'd15, 32'd0, 64'hffff_ffff_ffff_ffff);
    drain();
    calm = 1'b0;

    // Random phases over several window settings, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      logic [16:0] w;
      case (ph)
        0: w = 17'd65536;
        1: w = 17'h1ffff;
        2: w = 17'd1024;
        3: w = 17'($urandom_range(1024, 65536));
        default: w = 17'($urandom_range(0, 1023));
      endcase
      write_window(w);
      calm = (ph == 2);
      for (int i = 0; i < RAND_BEATS / 5; i++) begin
        queue_random_op((ph == 1 || ph == 3) ? (($urandom_range(9) == 0) ? 65536 : 256)
                                              : ((w == 0) ? 1 : int'(w)));
      end
      // Pause the sender once until the block has fully drained.
      if (ph == 3) begin
        while (pending_ops.size() > 60) @(posedge clk);
        hold_input = 1'b1;
        while (in_valid || expected_results.size() != 0) @(posedge clk);
        hold_input = 1'b0;
      end
      drain();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
